[sv/wmmf_pkg.sv]
// Package for the weighted max-min fair share core.
// Holds field widths, payload structs, datapath command codes and status struct.
// No dependencies.
package wmmf_pkg;

  localparam int UNIT_BITS       = 32;
  localparam int WEIGHT_BITS     = 16;
  localparam int MAX_DEMANDS_DEF = 64;

  typedef struct packed {
    logic [UNIT_BITS-1:0]   demand_units;
    logic [WEIGHT_BITS-1:0] demand_weight;
    logic                   last_demand;
  } in_t;

  typedef struct packed {
    logic [UNIT_BITS-1:0] allocated_units;
    logic                 short_of_demand;
    logic                 last_share;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIND_INIT,
    OP_IDX_CLR,
    OP_RD,
    OP_GRANT_RD,
    OP_FIND_MUL,
    OP_FIND_CMP,
    OP_NEED_INIT,
    OP_DIV_LEVEL,
    OP_NEED_ACC,
    OP_APPLY,
    OP_APPLY_END,
    OP_SPLIT_INIT,
    OP_DIV_SPLIT,
    OP_SPLIT_ACC,
    OP_LEFT_INIT,
    OP_PICK_INIT,
    OP_PICK_CMP,
    OP_GRANT_WR,
    OP_OUT_LOAD,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic adv;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic any_active;
    logic cap_zero;
    logic idx_last;
    logic elig;
    logic not_best;
    logic div_done;
    logic cap_ge_need;
    logic left_zero;
    logic best_vld;
  } sts_t;

endpackage

[sv/wmmf_div.sv]
// Iterative multiply-then-divide unit: floor(a*b/d) and remainder, one bit per cycle.
// Depends on nothing but its parameters.
module wmmf_div #(
  parameter int A_W = 32,
  parameter int B_W = 16,
  parameter int D_W = 22
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  input  logic [D_W-1:0] d,
  output logic           done,
  output logic [A_W-1:0] q,
  output logic [D_W-1:0] r
);

  localparam int PROD_W = A_W + B_W;
  localparam int CNT_W  = $clog2(PROD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] prod_r;
  logic [D_W-1:0]    rem_r;
  logic [D_W-1:0]    d_r;
  logic [D_W:0]      trial;
  logic [D_W:0]      diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, prod_r[PROD_W-1]};
    ge    = (trial >= {1'b0, d_r});
    diff  = trial - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift quotient bits in from the bottom while the product drains out the top
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
      rem_r  <= '0;
      d_r    <= d;
    end else if (busy_r) begin
      prod_r <= {prod_r[PROD_W-2:0], ge};
      rem_r  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign done = done_r;
  assign q    = prod_r[A_W-1:0];
  assign r    = rem_r;

endmodule

[sv/wmmf_dp.sv]
// Datapath of the fair share core: demand stores, level search, fill, split and leftover arithmetic.
// Depends on wmmf_pkg and wmmf_div.
module wmmf_dp #(
  parameter int MAX_DEMANDS = wmmf_pkg::MAX_DEMANDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wmmf_pkg::cmd_t                 cmd,
  output wmmf_pkg::sts_t                 sts,
  input  wmmf_pkg::in_t                  in_data,
  input  logic                           cfg_we,
  input  logic [wmmf_pkg::UNIT_BITS-1:0] cfg_wdata,
  output wmmf_pkg::out_t                 out_data
);

  localparam int U      = wmmf_pkg::UNIT_BITS;
  localparam int W      = wmmf_pkg::WEIGHT_BITS;
  localparam int IDX_W  = (MAX_DEMANDS > 1) ? $clog2(MAX_DEMANDS) : 1;
  localparam int CNT_W  = $clog2(MAX_DEMANDS + 1);
  localparam int SUMW_W = W + $clog2(MAX_DEMANDS);
  localparam int NEED_W = U + $clog2(MAX_DEMANDS);
  localparam int PR_W   = U + W;

  logic [W-1:0]      w_mem    [MAX_DEMANDS];
  logic [U-1:0]      orig_mem [MAX_DEMANDS];
  logic [U-1:0]      rem_mem  [MAX_DEMANDS];
  logic [U-1:0]      gr_mem   [MAX_DEMANDS];
  logic [SUMW_W-1:0] rmd_mem  [MAX_DEMANDS];
  logic [U-1:0]      scr_mem  [MAX_DEMANDS];

  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       n_r;
  logic [IDX_W-1:0]       idx_r;
  logic [MAX_DEMANDS-1:0] active_r;
  logic [MAX_DEMANDS-1:0] picked_r;
  logic                   best_vld_r;
  logic [U-1:0]           cap_cfg_r;
  logic [U-1:0]           cap_left_r;

  logic [IDX_W-1:0]  best_r;
  logic [U-1:0]      bu_r;
  logic [W-1:0]      bw_r;
  logic [SUMW_W-1:0] brem_r;
  logic [SUMW_W-1:0] total_w_r;
  logic [NEED_W-1:0] needed_r;
  logic [U-1:0]      dist_r;
  logic [U-1:0]      leftover_r;
  logic [PR_W-1:0]   p1_r;
  logic [PR_W-1:0]   p2_r;
  logic [W-1:0]      rd_w_r;
  logic [U-1:0]      rd_orig_r;
  logic [U-1:0]      rd_rem_r;
  logic [U-1:0]      rd_gr_r;
  logic [SUMW_W-1:0] rd_rmd_r;
  logic [U-1:0]      rd_scr_r;
  wmmf_pkg::out_t    out_data_r;

  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;
  logic              load_last;
  logic              cur_act;
  logic              is_best;
  logic              div_start;
  logic [U-1:0]      div_a;
  logic [SUMW_W-1:0] div_d;
  logic              div_done;
  logic [U-1:0]      div_q;
  logic [SUMW_W-1:0] div_r;
  logic              rem_we;
  logic [U-1:0]      rem_wd;
  logic              gr_we;
  logic [U-1:0]      gr_wd;

  assign slot      = cnt_r[IDX_W-1:0];
  assign load_last = in_data.last_demand || (cnt_r == CNT_W'(MAX_DEMANDS - 1));
  assign cur_act   = active_r[idx_r];
  assign is_best   = (idx_r == best_r);
  assign rd_en     = (cmd.op == wmmf_pkg::OP_RD) || (cmd.op == wmmf_pkg::OP_GRANT_RD);
  assign rd_addr   = (cmd.op == wmmf_pkg::OP_GRANT_RD) ? best_r : idx_r;

  always_comb begin
    case (cmd.op)
      wmmf_pkg::OP_LOAD:     wr_addr = slot;
      wmmf_pkg::OP_GRANT_WR: wr_addr = best_r;
      default:               wr_addr = idx_r;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = bu_r;
    div_d     = SUMW_W'(bw_r);
    case (cmd.op)
      wmmf_pkg::OP_DIV_LEVEL: div_start = 1'b1;
      wmmf_pkg::OP_DIV_SPLIT: begin
        div_start = 1'b1;
        div_a     = cap_left_r;
        div_d     = total_w_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    rem_we = 1'b0;
    rem_wd = in_data.demand_units;
    gr_we  = 1'b0;
    gr_wd  = '0;
    case (cmd.op)
      wmmf_pkg::OP_LOAD: begin
        rem_we = 1'b1;
        gr_we  = 1'b1;
      end
      wmmf_pkg::OP_APPLY: begin
        rem_we = cur_act;
        rem_wd = is_best ? '0 : rd_rem_r - rd_scr_r;
        gr_we  = cur_act;
        gr_wd  = rd_gr_r + (is_best ? bu_r : rd_scr_r);
      end
      wmmf_pkg::OP_SPLIT_ACC: begin
        gr_we = 1'b1;
        gr_wd = rd_gr_r + div_q;
      end
      wmmf_pkg::OP_GRANT_WR: begin
        gr_we = 1'b1;
        gr_wd = rd_gr_r + U'(1);
      end
      default: ;
    endcase
  end

  wmmf_div #(.A_W(U), .B_W(W), .D_W(SUMW_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (rd_w_r),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q),
    .r     (div_r)
  );

  // stores
  always_ff @(posedge clk) begin
    if (cmd.op == wmmf_pkg::OP_LOAD) begin
      w_mem[wr_addr]    <= in_data.demand_weight;
      orig_mem[wr_addr] <= in_data.demand_units;
    end
    if (rem_we) rem_mem[wr_addr] <= rem_wd;
    if (gr_we) gr_mem[wr_addr] <= gr_wd;
    if (cmd.op == wmmf_pkg::OP_SPLIT_ACC) rmd_mem[wr_addr] <= div_r;
    if (cmd.op == wmmf_pkg::OP_NEED_ACC) scr_mem[wr_addr] <= div_q;
    if (rd_en) begin
      rd_w_r    <= w_mem[rd_addr];
      rd_orig_r <= orig_mem[rd_addr];
      rd_rem_r  <= rem_mem[rd_addr];
      rd_gr_r   <= gr_mem[rd_addr];
      rd_rmd_r  <= rmd_mem[rd_addr];
      rd_scr_r  <= scr_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      n_r        <= '0;
      idx_r      <= '0;
      active_r   <= '0;
      picked_r   <= '0;
      best_vld_r <= 1'b0;
      cap_cfg_r  <= '0;
      cap_left_r <= '0;
    end else begin
      if (cfg_we) cap_cfg_r <= cfg_wdata;
      if (cmd.adv) idx_r <= idx_r + 1'b1;
      case (cmd.op)
        wmmf_pkg::OP_LOAD: begin
          cnt_r          <= cnt_r + 1'b1;
          active_r[slot] <= (in_data.demand_units != '0) && (in_data.demand_weight != '0);
          if (load_last) begin
            n_r        <= cnt_r + 1'b1;
            cap_left_r <= cap_cfg_r;
          end
        end
        wmmf_pkg::OP_FIND_INIT,
        wmmf_pkg::OP_PICK_INIT: begin
          idx_r      <= '0;
          best_vld_r <= 1'b0;
        end
        wmmf_pkg::OP_IDX_CLR,
        wmmf_pkg::OP_NEED_INIT,
        wmmf_pkg::OP_SPLIT_INIT: idx_r <= '0;
        wmmf_pkg::OP_FIND_CMP: begin
          if (cur_act && (!best_vld_r || (p1_r < p2_r))) best_vld_r <= 1'b1;
        end
        wmmf_pkg::OP_PICK_CMP: begin
          if (cur_act && !picked_r[idx_r] && (!best_vld_r || (rd_rmd_r > brem_r))) begin
            best_vld_r <= 1'b1;
          end
        end
        wmmf_pkg::OP_APPLY_END: begin
          cap_left_r       <= cap_left_r - needed_r[U-1:0];
          active_r[best_r] <= 1'b0;
        end
        wmmf_pkg::OP_LEFT_INIT: picked_r <= '0;
        wmmf_pkg::OP_GRANT_WR:  picked_r[best_r] <= 1'b1;
        wmmf_pkg::OP_FINISH: begin
          active_r <= '0;
          cnt_r    <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      wmmf_pkg::OP_FIND_INIT: total_w_r <= '0;
      wmmf_pkg::OP_FIND_MUL: begin
        p1_r <= PR_W'(rd_rem_r) * PR_W'(bw_r);
        p2_r <= PR_W'(bu_r) * PR_W'(rd_w_r);
      end
      wmmf_pkg::OP_FIND_CMP: begin
        if (cur_act) begin
          total_w_r <= total_w_r + SUMW_W'(rd_w_r);
          if (!best_vld_r || (p1_r < p2_r)) begin
            best_r <= idx_r;
            bu_r   <= rd_rem_r;
            bw_r   <= rd_w_r;
          end
        end
      end
      wmmf_pkg::OP_NEED_INIT: needed_r <= NEED_W'(bu_r);
      wmmf_pkg::OP_NEED_ACC:  needed_r <= needed_r + NEED_W'(div_q);
      wmmf_pkg::OP_SPLIT_INIT: dist_r <= '0;
      wmmf_pkg::OP_SPLIT_ACC:  dist_r <= dist_r + div_q;
      wmmf_pkg::OP_LEFT_INIT:  leftover_r <= cap_left_r - dist_r;
      wmmf_pkg::OP_PICK_CMP: begin
        if (cur_act && !picked_r[idx_r] && (!best_vld_r || (rd_rmd_r > brem_r))) begin
          best_r <= idx_r;
          brem_r <= rd_rmd_r;
        end
      end
      wmmf_pkg::OP_GRANT_WR: leftover_r <= leftover_r - U'(1);
      wmmf_pkg::OP_OUT_LOAD: begin
        out_data_r.allocated_units <= rd_gr_r;
        out_data_r.short_of_demand <= (rd_gr_r < rd_orig_r);
        out_data_r.last_share      <= (idx_r == IDX_W'(n_r - 1'b1));
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.load_last   = load_last;
    sts.any_active  = |active_r;
    sts.cap_zero    = (cap_left_r == '0);
    sts.idx_last    = (idx_r == IDX_W'(n_r - 1'b1));
    sts.elig        = cur_act;
    sts.not_best    = !is_best;
    sts.div_done    = div_done;
    sts.cap_ge_need = (NEED_W'(cap_left_r) >= needed_r);
    sts.left_zero   = (leftover_r == '0);
    sts.best_vld    = best_vld_r;
  end

  assign out_data = out_data_r;

endmodule

[sv/wmmf_ctrl.sv]
// Controller of the fair share core: sequences loads, filling rounds, split, leftover grants and output.
// Depends on wmmf_pkg.
module wmmf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  wmmf_pkg::sts_t sts,
  output wmmf_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_FIND_RD, S_FIND_MUL, S_FIND_CMP,
    S_NEED_INIT, S_NEED_RD, S_NEED_SEL, S_NEED_WAIT, S_DECIDE,
    S_APPLY_RD, S_APPLY_WR, S_APPLY_END,
    S_SPLIT_RD, S_SPLIT_SEL, S_SPLIT_WAIT,
    S_LEFT_INIT, S_LEFT_CHK, S_PICK_RD, S_PICK_CMP, S_PICK_END, S_GRANT_WR,
    S_OUT_RD, S_OUT_SHOW, S_OUT_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = wmmf_pkg::OP_NONE;
    cmd.adv       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = wmmf_pkg::OP_LOAD;
          if (sts.load_last) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.any_active || sts.cap_zero) begin
          cmd.op    = wmmf_pkg::OP_IDX_CLR;
          state_nxt = S_OUT_RD;
        end else begin
          cmd.op    = wmmf_pkg::OP_FIND_INIT;
          state_nxt = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        cmd.op    = wmmf_pkg::OP_RD;
        state_nxt = S_FIND_MUL;
      end
      S_FIND_MUL: begin
        cmd.op    = wmmf_pkg::OP_FIND_MUL;
        state_nxt = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        cmd.op    = wmmf_pkg::OP_FIND_CMP;
        cmd.adv   = 1'b1;
        state_nxt = sts.idx_last ? S_NEED_INIT : S_FIND_RD;
      end
      S_NEED_INIT: begin
        cmd.op    = wmmf_pkg::OP_NEED_INIT;
        state_nxt = S_NEED_RD;
      end
      S_NEED_RD: begin
        cmd.op    = wmmf_pkg::OP_RD;
        state_nxt = S_NEED_SEL;
      end
      S_NEED_SEL: begin
        if (sts.elig && sts.not_best) begin
          cmd.op    = wmmf_pkg::OP_DIV_LEVEL;
          state_nxt = S_NEED_WAIT;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = sts.idx_last ? S_DECIDE : S_NEED_RD;
        end
      end
      S_NEED_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = wmmf_pkg::OP_NEED_ACC;
          cmd.adv   = 1'b1;
          state_nxt = sts.idx_last ? S_DECIDE : S_NEED_RD;
        end
      end
      S_DECIDE: begin
        if (sts.cap_ge_need) begin
          cmd.op    = wmmf_pkg::OP_IDX_CLR;
          state_nxt = S_APPLY_RD;
        end else begin
          cmd.op    = wmmf_pkg::OP_SPLIT_INIT;
          state_nxt = S_SPLIT_RD;
        end
      end
      S_APPLY_RD: begin
        cmd.op    = wmmf_pkg::OP_RD;
        state_nxt = S_APPLY_WR;
      end
      S_APPLY_WR: begin
        cmd.op    = wmmf_pkg::OP_APPLY;
        cmd.adv   = 1'b1;
        state_nxt = sts.idx_last ? S_APPLY_END : S_APPLY_RD;
      end
      S_APPLY_END: begin
        cmd.op    = wmmf_pkg::OP_APPLY_END;
        state_nxt = S_CHECK;
      end
      S_SPLIT_RD: begin
        cmd.op    = wmmf_pkg::OP_RD;
        state_nxt = S_SPLIT_SEL;
      end
      S_SPLIT_SEL: begin
        if (sts.elig) begin
          cmd.op    = wmmf_pkg::OP_DIV_SPLIT;
          state_nxt = S_SPLIT_WAIT;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = sts.idx_last ? S_LEFT_INIT : S_SPLIT_RD;
        end
      end
      S_SPLIT_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = wmmf_pkg::OP_SPLIT_ACC;
          cmd.adv   = 1'b1;
          state_nxt = sts.idx_last ? S_LEFT_INIT : S_SPLIT_RD;
        end
      end
      S_LEFT_INIT: begin
        cmd.op    = wmmf_pkg::OP_LEFT_INIT;
        state_nxt = S_LEFT_CHK;
      end
      S_LEFT_CHK: begin
        if (sts.left_zero) begin
          cmd.op    = wmmf_pkg::OP_IDX_CLR;
          state_nxt = S_OUT_RD;
        end else begin
          cmd.op    = wmmf_pkg::OP_PICK_INIT;
          state_nxt = S_PICK_RD;
        end
      end
      S_PICK_RD: begin
        cmd.op    = wmmf_pkg::OP_RD;
        state_nxt = S_PICK_CMP;
      end
      S_PICK_CMP: begin
        cmd.op    = wmmf_pkg::OP_PICK_CMP;
        cmd.adv   = 1'b1;
        state_nxt = sts.idx_last ? S_PICK_END : S_PICK_RD;
      end
      S_PICK_END: begin
        if (sts.best_vld) begin
          cmd.op    = wmmf_pkg::OP_GRANT_RD;
          state_nxt = S_GRANT_WR;
        end else begin
          cmd.op    = wmmf_pkg::OP_IDX_CLR;
          state_nxt = S_OUT_RD;
        end
      end
      S_GRANT_WR: begin
        cmd.op    = wmmf_pkg::OP_GRANT_WR;
        state_nxt = S_LEFT_CHK;
      end
      S_OUT_RD: begin
        cmd.op    = wmmf_pkg::OP_RD;
        state_nxt = S_OUT_SHOW;
      end
      S_OUT_SHOW: begin
        cmd.op        = wmmf_pkg::OP_OUT_LOAD;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (sts.idx_last) begin
            cmd.op    = wmmf_pkg::OP_FINISH;
            state_nxt = S_IDLE;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[sv/weighted_max_min_fair_share_core.sv]
// Load: one demand transaction per cycle while idle; non-final loads return nothing.
// Share: after the final load, rounds of level search and fill run over the stored
//   demands, then a split and leftover grants if capacity falls short; each division
//   runs in the shared bit-serial divider.
// Output: n result transactions, each waiting on out_ready.
// Reset: synchronous active-low rst_n clears control state and the capacity register.
module weighted_max_min_fair_share_core #(
  parameter int MAX_DEMANDS = wmmf_pkg::MAX_DEMANDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wmmf_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wmmf_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [wmmf_pkg::UNIT_BITS-1:0] cfg_wdata
);

  // command and status between the sequencer and the datapath
  wmmf_pkg::cmd_t cmd;
  wmmf_pkg::sts_t sts;

  // controller: walks the load, fill, split, leftover and output phases
  wmmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: stores, level compare, divider and result register
  wmmf_dp #(.MAX_DEMANDS(MAX_DEMANDS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

[sv/wmmf_chk.sv]
// Port checker for the fair share core, bound to the top level.
// Depends on wmmf_pkg and weighted_max_min_fair_share_core.
module wmmf_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input wmmf_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_share |=> in_ready && !out_valid)
    else $error("block not idle after final result");

endmodule

bind weighted_max_min_fair_share_core wmmf_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
